// File: rtl/mfts_pkg.sv
// ----------------------------------------------------------------------------
// mfts_pkg
// Shared types and constants of the music fade track switcher.
// ----------------------------------------------------------------------------
package mfts_pkg;

   // Fade volume range and step.
   localparam logic [10:0] FADE_MAX  = 11'd1024;
   localparam logic [10:0] FADE_STEP = 11'd16;

   // Fixed-point reciprocals of 100, exact for the operand ranges used here.
   // The first is used with a right shift of 24, the second with a shift of 25.
   localparam logic [18:0] RECIP_100_S24 = 19'd167773;
   localparam logic [18:0] RECIP_100_S25 = 19'd335545;

   // Item kinds carried on the request tuser.
   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_SELECT  = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_PAUSE   = 3'd3,
      KIND_RESUME  = 3'd4,
      KIND_CLEANUP = 3'd5
   } kind_type;

   // Player commands.
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_HALT    = 3'd3,
      CMD_RESTART = 3'd4
   } player_cmd_type;

   // Configuration register indexes.
   localparam logic CSR_MASTER_VOLUME = 1'b0;
   localparam logic CSR_MUSIC_VOLUME  = 1'b1;

   // Operation of the shared multiplier.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_MUSIC  = 3'd1,
      OP_RECIP1 = 3'd2,
      OP_MASTER = 3'd3,
      OP_RECIP2 = 3'd4
   } mul_op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_MUL_MUSIC  = 3'd1,
      ST_MUL_RECIP1 = 3'd2,
      ST_MUL_MASTER = 3'd3,
      ST_MUL_RECIP2 = 3'd4,
      ST_DONE       = 3'd5
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      mul_op_type op;
      logic       load_out;
   } dp_cmd_type;

endpackage

// File: rtl/mfts_ctrl.sv
// ----------------------------------------------------------------------------
// mfts_ctrl
// Controller: handshakes, multiply sequence and result register valid.
// ----------------------------------------------------------------------------
module mfts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mfts_pkg::dp_cmd_type cmd
);
   import mfts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.op       = OP_NONE;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL_MUSIC;
            end
         end
         ST_MUL_MUSIC: begin
            cmd.op   = OP_MUSIC;
            state_in = ST_MUL_RECIP1;
         end
         ST_MUL_RECIP1: begin
            cmd.op   = OP_RECIP1;
            state_in = ST_MUL_MASTER;
         end
         ST_MUL_MASTER: begin
            cmd.op   = OP_MASTER;
            state_in = ST_MUL_RECIP2;
         end
         ST_MUL_RECIP2: begin
            cmd.op   = OP_RECIP2;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL_MUSIC))
      else $error("accepted item did not start the multiply sequence");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while still held");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

// File: rtl/mfts_dp.sv
// ----------------------------------------------------------------------------
// mfts_dp
// Datapath: player state, configuration, shared multiplier, result register.
// ----------------------------------------------------------------------------
module mfts_dp #(
   parameter int TRACK_COUNT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfts_pkg::dp_cmd_type cmd,
   input  logic [2:0]           in_kind,
   input  logic [3:0]           in_track,
   input  logic                 csr_wr_en,
   input  logic [0:0]           csr_index,
   input  logic [6:0]           csr_wdata,
   output logic [2:0]           out_player_cmd,
   output logic [3:0]           out_cmd_track,
   output logic [10:0]          out_level,
   output logic                 out_level_written,
   output logic                 out_is_playing,
   output logic                 out_is_paused
);
   import mfts_pkg::*;

   localparam logic [8:0] TRACK_LIMIT = 9'(TRACK_COUNT);

   // Configuration.
   logic [6:0]  master_ff, music_ff;

   // Player state.
   logic [10:0] fade_ff, fade_in;
   logic        playing_ff, playing_in;
   logic        paused_ff, paused_in;
   logic        stop_pend_ff, stop_pend_in;
   logic [3:0]  cur_track_ff, cur_track_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [3:0]  nxt_track_ff, nxt_track_in;
   logic        nxt_valid_ff, nxt_valid_in;
   logic [3:0]  ld_track_ff, ld_track_in;

   // Per-item result held while the level is computed.
   player_cmd_type pcmd_ff, pcmd_in;
   logic [3:0]  ctrk_ff, ctrk_in;
   logic        wrote_ff, wrote_in;

   // Shared multiplier.
   logic [37:0] acc_ff, acc_in;
   logic [18:0] mul_a, mul_b;

   // Result register.
   logic [2:0]  rsp_cmd_ff;
   logic [3:0]  rsp_ctrk_ff;
   logic [10:0] rsp_level_ff;
   logic        rsp_wrote_ff, rsp_play_ff, rsp_pause_ff;

   logic [10:0] fade_dn, fade_up, level_raw, level_sat;
   logic        differ;

   assign fade_dn = (fade_ff > FADE_STEP) ? (fade_ff - FADE_STEP) : '0;
   assign fade_up = ((fade_ff + FADE_STEP) > FADE_MAX) ? FADE_MAX : (fade_ff + FADE_STEP);
   assign differ  = (nxt_valid_ff != cur_valid_ff) ||
                    (nxt_valid_ff && (nxt_track_ff != cur_track_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= 7'd100;
         music_ff     <= 7'd100;
         fade_ff      <= FADE_MAX;
         playing_ff   <= 1'b0;
         paused_ff    <= 1'b0;
         stop_pend_ff <= 1'b0;
         cur_track_ff <= '0;
         cur_valid_ff <= 1'b0;
         nxt_track_ff <= '0;
         nxt_valid_ff <= 1'b0;
         ld_track_ff  <= '0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_MASTER_VOLUME)) begin
            master_ff <= csr_wdata;
         end
         if (csr_wr_en && (csr_index == CSR_MUSIC_VOLUME)) begin
            music_ff <= csr_wdata;
         end
         fade_ff      <= fade_in;
         playing_ff   <= playing_in;
         paused_ff    <= paused_in;
         stop_pend_ff <= stop_pend_in;
         cur_track_ff <= cur_track_in;
         cur_valid_ff <= cur_valid_in;
         nxt_track_ff <= nxt_track_in;
         nxt_valid_ff <= nxt_valid_in;
         ld_track_ff  <= ld_track_in;
      end
   end

   // Event handling, applied at the transfer of an item.
   always_comb begin
      fade_in      = fade_ff;
      playing_in   = playing_ff;
      paused_in    = paused_ff;
      stop_pend_in = stop_pend_ff;
      cur_track_in = cur_track_ff;
      cur_valid_in = cur_valid_ff;
      nxt_track_in = nxt_track_ff;
      nxt_valid_in = nxt_valid_ff;
      ld_track_in  = ld_track_ff;
      pcmd_in      = pcmd_ff;
      ctrk_in      = ctrk_ff;
      wrote_in     = wrote_ff;
      if (cmd.accept) begin
         pcmd_in  = CMD_NONE;
         ctrk_in  = '0;
         wrote_in = 1'b0;
         case (in_kind)
            KIND_TICK: begin
               if (stop_pend_ff) begin
                  if (playing_ff) begin
                     fade_in  = fade_dn;
                     wrote_in = 1'b1;
                     if (fade_dn == '0) begin
                        pcmd_in      = CMD_STOP;
                        playing_in   = 1'b0;
                        paused_in    = 1'b0;
                        stop_pend_in = 1'b0;
                        cur_valid_in = 1'b0;
                        nxt_valid_in = 1'b0;
                     end
                  end else begin
                     stop_pend_in = 1'b0;
                  end
               end else if (differ) begin
                  if (!playing_ff) begin
                     if (nxt_valid_ff) begin
                        ld_track_in  = nxt_track_ff;
                        pcmd_in      = CMD_START;
                        ctrk_in      = nxt_track_ff;
                        wrote_in     = 1'b1;
                        playing_in   = 1'b1;
                        cur_track_in = nxt_track_ff;
                        cur_valid_in = 1'b1;
                     end else begin
                        cur_valid_in = 1'b0;
                     end
                  end else begin
                     fade_in  = fade_dn;
                     wrote_in = 1'b1;
                     if (fade_dn == '0) begin
                        pcmd_in    = CMD_STOP;
                        playing_in = 1'b0;
                        paused_in  = 1'b0;
                     end
                  end
               end else if (fade_ff < FADE_MAX) begin
                  fade_in  = fade_up;
                  wrote_in = 1'b1;
               end
            end
            KIND_SELECT: begin
               if ({5'b0, in_track} < TRACK_LIMIT) begin
                  nxt_track_in = in_track;
                  nxt_valid_in = 1'b1;
               end
            end
            KIND_STOP: begin
               stop_pend_in = 1'b1;
            end
            KIND_PAUSE: begin
               if (playing_ff && !paused_ff) begin
                  pcmd_in   = CMD_HALT;
                  paused_in = 1'b1;
               end
            end
            KIND_RESUME: begin
               if (playing_ff && paused_ff) begin
                  pcmd_in   = CMD_RESTART;
                  ctrk_in   = ld_track_ff;
                  paused_in = 1'b0;
               end
            end
            KIND_CLEANUP: begin
               if (playing_ff) begin
                  pcmd_in    = CMD_STOP;
                  playing_in = 1'b0;
                  paused_in  = 1'b0;
               end
               stop_pend_in = 1'b0;
               cur_valid_in = 1'b0;
               nxt_valid_in = 1'b0;
               fade_in      = FADE_MAX;
            end
            default: begin
            end
         endcase
      end
   end

   // Level = ((fade * music) / 100 * master) / 100, each divide done as a
   // multiply by a reciprocal and a shift, one multiply per cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUSIC: begin
            mul_a = {8'b0, fade_ff};
            mul_b = {12'b0, music_ff};
         end
         OP_RECIP1: begin
            mul_a = {2'b0, acc_ff[16:0]};
            mul_b = RECIP_100_S24;
         end
         OP_MASTER: begin
            mul_a = {8'b0, acc_ff[34:24]};
            mul_b = {12'b0, master_ff};
         end
         OP_RECIP2: begin
            mul_a = {1'b0, acc_ff[17:0]};
            mul_b = RECIP_100_S25;
         end
         default: begin
         end
      endcase
      acc_in = (cmd.op == OP_NONE) ? acc_ff : (mul_a * mul_b);
   end

   assign level_raw = acc_ff[35:25];
   assign level_sat = (level_raw > FADE_MAX) ? FADE_MAX : level_raw;

   always_ff @(posedge clock) begin
      pcmd_ff  <= pcmd_in;
      ctrk_ff  <= ctrk_in;
      wrote_ff <= wrote_in;
      acc_ff   <= acc_in;
      if (cmd.load_out) begin
         rsp_cmd_ff   <= pcmd_ff;
         rsp_ctrk_ff  <= ctrk_ff;
         rsp_level_ff <= wrote_ff ? level_sat : '0;
         rsp_wrote_ff <= wrote_ff;
         rsp_play_ff  <= playing_ff;
         rsp_pause_ff <= paused_ff;
      end
   end

   assign out_player_cmd    = rsp_cmd_ff;
   assign out_cmd_track     = rsp_ctrk_ff;
   assign out_level         = rsp_level_ff;
   assign out_level_written = rsp_wrote_ff;
   assign out_is_playing    = rsp_play_ff;
   assign out_is_paused     = rsp_pause_ff;

`ifndef NO_ASSERTIONS
   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      fade_ff <= FADE_MAX)
      else $error("fade volume beyond full scale");

   a_paused_needs_playing: assert property (@(posedge clock) disable iff (reset)
      paused_ff |-> playing_ff)
      else $error("paused while not playing");
`endif

endmodule

// File: rtl/music_fade_track_switcher.sv
// ----------------------------------------------------------------------------
// music_fade_track_switcher
// Background-music fade controller and track switcher, top level.
// ----------------------------------------------------------------------------
// Each request transfer carries one event (tick, select track, stop request,
// pause, resume or clean up) and produces exactly one response transfer with
// the player command, its track, the scaled level and the playing and paused
// flags. The block works on one item at a time: the idle state accepts the
// event and updates the player state, the multiply states use a single shared
// multiplier to form fade * music, the divide by 100, the product with master
// and the second divide by 100, and the done state loads the response
// register. The
// response register lets a finished result wait on the output while the next
// event is accepted and worked on; only its final load waits for the register
// to be free. Volume writes on the csr port take effect at once and are meant
// for times when no item is in flight.
// ----------------------------------------------------------------------------
module music_fade_track_switcher #(
   parameter int TRACK_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] track, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] player_cmd, [6:3] cmd_track,
                                    // [17:7] level, [18] is_playing,
                                    // [19] is_paused, [23:20] zero
   output logic [0:0]  rsp_tuser,   // [0] level_written
   // Configuration port: index 0 master volume, index 1 music volume.
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import mfts_pkg::*;

   dp_cmd_type  dp_cmd;
   logic [2:0]  player_cmd;
   logic [3:0]  cmd_track;
   logic [10:0] level;
   logic        level_written;
   logic        is_playing;
   logic        is_paused;

   // The controller sequences every transfer and the multiply passes.
   mfts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd)
   );

   // The datapath holds the player state, the volumes and the result.
   mfts_dp #(
      .TRACK_COUNT (TRACK_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .in_kind           (req_tuser),
      .in_track          (req_tdata[3:0]),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .out_player_cmd    (player_cmd),
      .out_cmd_track     (cmd_track),
      .out_level         (level),
      .out_level_written (level_written),
      .out_is_playing    (is_playing),
      .out_is_paused     (is_paused)
   );

   // Pack the response fields, lowest field in the lowest bits.
   assign rsp_tdata = {4'b0, is_paused, is_playing, level, cmd_track, player_cmd};
   assign rsp_tuser = level_written;

endmodule
